/* rtl/hessenberg_lu_decompose_defines.svh */
// assertion macros shared by the hessenberg lu blocks
`ifndef HESSENBERG_LU_DECOMPOSE_DEFINES_SVH
`define HESSENBERG_LU_DECOMPOSE_DEFINES_SVH
`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define HLU_ASSERT(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("hlu assertion failed");
// consequent holds in the same cycle as the antecedent
`define HLU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hlu assertion failed");
// consequent holds in the cycle after the antecedent
`define HLU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hlu assertion failed");
`else
`define HLU_ASSERT(lbl, clk, rst, cond)
`define HLU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define HLU_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/hlu_pkg.sv */
package hlu_pkg;

   // sizes
   localparam int HLU_MAX_SIZE  = 256;
   localparam int HLU_SIZE_W    = 9;
   localparam int HLU_DATA_W    = 32;
   localparam int HLU_IDX_W     = 8;
   localparam int HLU_FRAC_BITS = 16;
   localparam int HLU_DIV_STEPS = HLU_DATA_W + HLU_FRAC_BITS;

   localparam logic [HLU_SIZE_W-1:0] HLU_SIZE_RESET = 9'd4;

   // q16.16 limits
   localparam logic [HLU_DATA_W-1:0] HLU_Q_MAX = 32'h7fff_ffff;
   localparam logic [HLU_DATA_W-1:0] HLU_Q_MIN = 32'h8000_0000;

   typedef logic signed [HLU_DATA_W-1:0] hlu_data_type;
   typedef logic [HLU_IDX_W-1:0]         hlu_idx_type;

endpackage

/* rtl/hlu_req_if.sv */
interface hlu_req_if
   import hlu_pkg::*;
();
   logic         valid;
   logic         ready;
   hlu_data_type element_value;

   modport source (output valid, output element_value, input ready);
   modport sink (input valid, input element_value, output ready);
endinterface

/* rtl/hlu_rsp_if.sv */
interface hlu_rsp_if
   import hlu_pkg::*;
();
   logic         valid;
   logic         ready;
   hlu_data_type factor_value;
   hlu_idx_type  row_index;
   hlu_idx_type  col_index;
   logic         zero_pivot;
   logic         saturated;
   logic         last_entry;

   modport source (
      output valid, output factor_value, output row_index, output col_index,
      output zero_pivot, output saturated, output last_entry, input ready
   );
   modport sink (
      input valid, input factor_value, input row_index, input col_index,
      input zero_pivot, input saturated, input last_entry, output ready
   );
endinterface

/* rtl/hlu_ram.sv */
module hlu_ram
   import hlu_pkg::*;
#(
   parameter int WIDTH = HLU_DATA_W,
   parameter int DEPTH = HLU_MAX_SIZE
)
(
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* rtl/hlu_divider.sv */
`include "hessenberg_lu_decompose_defines.svh"

module hlu_divider
   import hlu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  hlu_data_type dividend,
   input  hlu_data_type divisor,
   output logic         done,
   output hlu_data_type quotient,
   output logic         clipped
);

   localparam int CNT_W = $clog2(HLU_DIV_STEPS);
   localparam int QW    = HLU_DIV_STEPS;
   localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(HLU_DIV_STEPS - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [32:0]      rem_ff, rem_in;
   logic [QW-1:0]    dvd_ff, dvd_in;
   logic [31:0]      dsr_ff, dsr_in;
   logic             neg_ff, neg_in;

   logic [31:0] mag_a;
   logic [31:0] mag_d;
   logic [32:0] shifted;
   logic [33:0] diff;
   logic        ge;

   // magnitudes of the operands; the dividend is scaled by 2^16 when loaded
   always_comb begin
      mag_a = dividend[31] ? ((~dividend) + 32'd1) : dividend;
      mag_d = divisor[31] ? ((~divisor) + 32'd1) : divisor;
   end

   // one restoring step: quotient bits shift in where dividend bits leave
   always_comb begin
      shifted = {rem_ff[31:0], dvd_ff[QW-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      ge      = !diff[33];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = {mag_a, {HLU_FRAC_BITS{1'b0}}};
         dsr_in  = mag_d;
         neg_in  = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         rem_in = ge ? diff[32:0] : shifted;
         dvd_in = {dvd_ff[QW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   // sign and saturation of the finished quotient
   always_comb begin
      quotient = dvd_ff[31:0];
      clipped  = 1'b0;
      if (neg_ff) begin
         if ((dvd_ff[QW-1:32] != '0) || (dvd_ff[31] && (dvd_ff[30:0] != '0))) begin
            quotient = HLU_Q_MIN;
            clipped  = 1'b1;
         end else begin
            quotient = (~dvd_ff[31:0]) + 32'd1;
         end
      end else if (dvd_ff[QW-1:31] != '0) begin
         quotient = HLU_Q_MAX;
         clipped  = 1'b1;
      end
   end

   assign done = done_ff;

   `HLU_ASSERT_IMP(a_div_start_idle, clock, reset, start, !busy_ff)
   `HLU_ASSERT_IMP(a_div_divisor_nonzero, clock, reset, start, divisor != '0)
   `HLU_ASSERT_NXT(a_div_done_after_last, clock, reset, busy_ff && (cnt_ff == STEP_LAST) && !start, done_ff && !busy_ff)

endmodule

/* rtl/hessenberg_lu_decompose.sv */
// path: accept, read state, put state, response register; U beats add the multiply state
//   and subdiagonal beats with a nonzero pivot add the divide state
// flow: one element at a time, taken in idle; divide waits on the 48-step radix-2 divider,
//   put on rsp ready; every beat reads the row memory at accept, pass and U beats write it
// reset: synchronous, active high; position, multiplier and flag clear, matrix_size = 4;
//   the row memory is not cleared and needs no clearing pass
`include "hessenberg_lu_decompose_defines.svh"

module hessenberg_lu_decompose
   import hlu_pkg::*;
#(
   parameter int MAX_SIZE = HLU_MAX_SIZE
)
(
   input  logic                  clock,
   input  logic                  reset,
   hlu_req_if.sink               req_bus,
   hlu_rsp_if.source             rsp_bus,
   input  logic                  csr_write_enable,
   input  logic [HLU_SIZE_W-1:0] csr_write_data
);

   localparam int CNT_W = $clog2(MAX_SIZE);
   localparam logic [CNT_W-1:0] LAST_MAX = CNT_W'(MAX_SIZE - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_PUT  = 3'd4;

   // position kinds
   localparam logic [1:0] KIND_PASS  = 2'd0;
   localparam logic [1:0] KIND_ZERO  = 2'd1;
   localparam logic [1:0] KIND_MULT  = 2'd2;
   localparam logic [1:0] KIND_UPPER = 2'd3;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      row_ff, row_in;
   logic [CNT_W-1:0]      col_ff, col_in;
   logic [HLU_SIZE_W-1:0] size_ff, size_in;
   hlu_data_type          mult_ff, mult_in;
   logic                  pzero_ff, pzero_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   hlu_data_type          a_ff, a_in;
   logic [1:0]            kind_ff, kind_in;
   logic signed [63:0]    prod_ff, prod_in;
   hlu_data_type          res_ff, res_in;
   logic                  clip_ff, clip_in;
   logic                  zp_ff, zp_in;

   hlu_data_type          rsp_value_ff, rsp_value_in;
   hlu_idx_type           rsp_row_ff, rsp_row_in;
   hlu_idx_type           rsp_col_ff, rsp_col_in;
   logic                  rsp_zp_ff, rsp_zp_in;
   logic                  rsp_sat_ff, rsp_sat_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [31:0]           size_m1;
   logic                  size_big;
   logic [CNT_W-1:0]      last_idx;
   logic [CNT_W:0]        col_p1;
   logic [1:0]            kind_c;
   logic                  req_accept;
   logic                  row_last;
   logic                  col_last;

   logic                  ram_we;
   hlu_data_type          ram_wdata;
   logic [HLU_DATA_W-1:0] ram_rdata;
   hlu_data_type          pivot;

   logic                  div_start;
   logic                  div_done;
   hlu_data_type          div_quot;
   logic                  div_clip;

   logic signed [48:0]    diff;
   logic                  diff_ovf;
   hlu_data_type          sat_value;

   // effective order, clamped to 1..MAX_SIZE, as a last index
   always_comb begin
      size_m1  = 32'(size_ff) - 32'd1;
      size_big = (32'(size_ff) > 32'(MAX_SIZE));
      if (size_big) begin
         last_idx = LAST_MAX;
      end else if (size_ff == '0) begin
         last_idx = '0;
      end else begin
         last_idx = size_m1[CNT_W-1:0];
      end
      row_last = (row_ff == last_idx);
      col_last = (col_ff == last_idx);
   end

   // classify the incoming position
   always_comb begin
      col_p1 = {1'b0, col_ff} + 1'b1;
      if (row_ff == '0) begin
         kind_c = KIND_PASS;
      end else if (col_p1 < {1'b0, row_ff}) begin
         kind_c = KIND_ZERO;
      end else if (col_p1 == {1'b0, row_ff}) begin
         kind_c = KIND_MULT;
      end else begin
         kind_c = KIND_UPPER;
      end
   end

   assign req_accept    = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign pivot         = $signed(ram_rdata);

   // u update: a - floor(l * uprev / 2^16), saturated
   always_comb begin
      diff      = {{17{a_ff[31]}}, a_ff} - {prod_ff[63], prod_ff[63:16]};
      diff_ovf  = (diff[48:31] != {18{diff[48]}});
      sat_value = diff_ovf ? (diff[48] ? HLU_Q_MIN : HLU_Q_MAX) : diff[31:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      size_in      = size_ff;
      mult_in      = mult_ff;
      pzero_in     = pzero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      a_in         = a_ff;
      kind_in      = kind_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      clip_in      = clip_ff;
      zp_in        = zp_ff;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_zp_in    = rsp_zp_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_wdata    = a_ff;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               a_in     = req_bus.element_value;
               kind_in  = kind_c;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            clip_in  = 1'b0;
            zp_in    = 1'b0;
            res_in   = '0;
            state_in = ST_PUT;
            case (kind_ff)
               KIND_PASS: begin
                  res_in    = a_ff;
                  ram_we    = 1'b1;
                  ram_wdata = a_ff;
               end
               KIND_ZERO: begin
                  res_in = '0;
               end
               KIND_MULT: begin
                  if (pivot == '0) begin
                     mult_in  = '0;
                     pzero_in = 1'b1;
                     zp_in    = 1'b1;
                  end else begin
                     pzero_in  = 1'b0;
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               KIND_UPPER: begin
                  prod_in  = mult_ff * pivot;
                  state_in = ST_MUL;
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               mult_in  = div_quot;
               res_in   = div_quot;
               clip_in  = div_clip;
               zp_in    = 1'b0;
               state_in = ST_PUT;
            end
         end
         ST_MUL: begin
            res_in    = sat_value;
            clip_in   = diff_ovf;
            zp_in     = pzero_ff;
            ram_we    = 1'b1;
            ram_wdata = sat_value;
            state_in  = ST_PUT;
         end
         ST_PUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_row_in   = 8'(row_ff);
               rsp_col_in   = 8'(col_ff);
               rsp_zp_in    = zp_ff;
               rsp_sat_in   = clip_ff;
               rsp_last_in  = row_last && col_last;
               // advance the position
               if (col_last) begin
                  col_in   = '0;
                  mult_in  = '0;
                  pzero_in = 1'b0;
                  row_in   = row_last ? '0 : row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // size write restarts the matrix
      if (csr_write_enable) begin
         size_in  = csr_write_data;
         row_in   = '0;
         col_in   = '0;
         mult_in  = '0;
         pzero_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         size_ff      <= HLU_SIZE_RESET;
         mult_ff      <= '0;
         pzero_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         size_ff      <= size_in;
         mult_ff      <= mult_in;
         pzero_ff     <= pzero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      kind_ff      <= kind_in;
      prod_ff      <= prod_in;
      res_ff       <= res_in;
      clip_ff      <= clip_in;
      zp_ff        <= zp_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_zp_ff    <= rsp_zp_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // previous u row, read at accept, written back on the same column
   hlu_ram #(
      .WIDTH (HLU_DATA_W),
      .DEPTH (MAX_SIZE)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (col_ff),
      .wr_data (ram_wdata),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (ram_rdata)
   );

   // row multiplier divider
   hlu_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a_ff),
      .divisor  (pivot),
      .done     (div_done),
      .quotient (div_quot),
      .clipped  (div_clip)
   );

   // result beat
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.factor_value = rsp_value_ff;
   assign rsp_bus.row_index    = rsp_row_ff;
   assign rsp_bus.col_index    = rsp_col_ff;
   assign rsp_bus.zero_pivot   = rsp_zp_ff;
   assign rsp_bus.saturated    = rsp_sat_ff;
   assign rsp_bus.last_entry   = rsp_last_ff;

   `HLU_ASSERT(a_pos_in_range, clock, reset, (row_ff <= last_idx) && (col_ff <= last_idx))
   `HLU_ASSERT_IMP(a_pzero_mult_zero, clock, reset, pzero_ff, mult_ff == '0)
   `HLU_ASSERT_IMP(a_store_write_state, clock, reset, ram_we, (state_ff == ST_READ) || (state_ff == ST_MUL))
   `HLU_ASSERT_NXT(a_accept_reads, clock, reset, req_accept, state_ff == ST_READ)
   `HLU_ASSERT_IMP(a_div_done_in_div, clock, reset, div_done, state_ff == ST_DIV)

endmodule
